### design/fir_filter_fixed_coefficients_macros.svh
// Assertion macros used by the FIR filter checker.
`ifndef FIR_FILTER_FIXED_COEFFICIENTS_MACROS_SVH
`define FIR_FILTER_FIXED_COEFFICIENTS_MACROS_SVH

// same-cycle implication, off during reset
`define FIRFC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define FIRFC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// what must hold in the cycle after reset
`define FIRFC_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

### design/firfc_pkg.sv
// Package: widths, coefficient table and cell control type of the FIR filter.
`timescale 1ns / 1ps

package firfc_pkg;

   localparam int DATA_W       = 32;
   localparam int COEF_W       = 16;
   localparam int ACC_W        = 48;
   localparam int OUT_SHIFT    = 16;
   localparam int COEF_COUNT   = 73;
   localparam int TAPS_DEFAULT = 73;

   // newest sample takes entry 0
   localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_COUNT] = '{
      -16'sd137, -16'sd73, 16'sd139, 16'sd210, 16'sd384, 16'sd339, 16'sd263, 16'sd69,
      -16'sd15, 16'sd0, 16'sd177, 16'sd352, 16'sd424, 16'sd275, -16'sd20, -16'sd318,
      -16'sd420, -16'sd273, 16'sd21, 16'sd211, 16'sd86, -16'sd387, -16'sd991,
      -16'sd1380, -16'sd1294, -16'sd772, -16'sd175, -16'sd6, -16'sd582, -16'sd1761,
      -16'sd2918, -16'sd3223, -16'sd2086, 16'sd449, 16'sd3620, 16'sd6243, 16'sd7258,
      16'sd6243, 16'sd3620, 16'sd449, -16'sd2086, -16'sd3223, -16'sd2918, -16'sd1761,
      -16'sd582, -16'sd6, -16'sd175, -16'sd772, -16'sd1294, -16'sd1380, -16'sd991,
      -16'sd387, 16'sd86, 16'sd211, 16'sd21, -16'sd273, -16'sd420, -16'sd318, -16'sd20,
      16'sd275, 16'sd424, 16'sd352, 16'sd177, 16'sd0, -16'sd15, 16'sd69, 16'sd263,
      16'sd339, 16'sd384, 16'sd210, 16'sd139, -16'sd73, -16'sd137
   };

   // taps past the table weigh zero
   function automatic logic signed [COEF_W-1:0] coef_at(input int k);
      logic signed [COEF_W-1:0] c;
      c = '0;
      if (k < COEF_COUNT) begin
         c = COEF_TABLE[k];
      end
      return c;
   endfunction

   typedef struct packed {
      logic load;   // register a new product
      logic acc;    // fold product into partial sum
   } firfc_ctrl_type;

endpackage

### design/firfc_cell.sv
// One tap cell of the transposed FIR chain: product register and partial sum register.
`timescale 1ns / 1ps

module firfc_cell #(
   parameter logic signed [firfc_pkg::COEF_W-1:0] COEF = firfc_pkg::coef_at(0)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  firfc_pkg::firfc_ctrl_type         ctrl,
   input  logic signed [firfc_pkg::DATA_W-1:0] sample,
   input  logic        [firfc_pkg::ACC_W-1:0]  sum_right,
   output logic        [firfc_pkg::ACC_W-1:0]  sum_out
);

   logic signed [firfc_pkg::ACC_W-1:0] prod_ff;
   logic signed [firfc_pkg::ACC_W-1:0] prod_in;
   logic        [firfc_pkg::ACC_W-1:0] sum_ff;
   logic        [firfc_pkg::ACC_W-1:0] sum_in;

   always_comb begin
      prod_in = sample * COEF;
      sum_in  = firfc_pkg::ACC_W'(prod_ff) + sum_right;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.acc) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_out = sum_ff;

endmodule

### design/fir_filter_fixed_coefficients.sv
// An accepted beat is registered in the product stage, then added into the partial sums.
// Throughput: one beat per cycle while rsp is not stalled; each tap cell holds one constant
// multiplier and one add. A result waiting under stall holds the chain; input is still
// taken while the product stage is empty.
// Reset: synchronous; clears all partial sums (history reads as zero) and both valid flags.
`timescale 1ns / 1ps

module fir_filter_fixed_coefficients #(
   parameter int unsigned TAPS = firfc_pkg::TAPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [firfc_pkg::DATA_W-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [firfc_pkg::DATA_W-1:0] rsp_filtered_out
);

   logic                       prod_valid_ff;
   logic                       prod_valid_in;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic                       adv_out;
   logic                       adv_prod;
   firfc_pkg::firfc_ctrl_type  ctrl;
   logic [firfc_pkg::ACC_W-1:0] sum_chain [TAPS+1];

   always_comb begin
      adv_out       = !out_valid_ff || !rsp_stall;
      adv_prod      = !prod_valid_ff || adv_out;
      ctrl.load     = req_valid && adv_prod;
      ctrl.acc      = prod_valid_ff && adv_out;
      prod_valid_in = adv_prod ? req_valid : prod_valid_ff;
      out_valid_in  = adv_out ? prod_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign sum_chain[TAPS] = '0;

   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      firfc_cell #(
         .COEF (firfc_pkg::coef_at(k))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .sample    (req_sample_in),
         .sum_right (sum_chain[k+1]),
         .sum_out   (sum_chain[k])
      );
   end

   assign req_stall        = !adv_prod;
   assign rsp_valid        = out_valid_ff;
   assign rsp_filtered_out =
      $signed(sum_chain[0][firfc_pkg::OUT_SHIFT +: firfc_pkg::DATA_W]);

endmodule

### design/firfc_checker.sv
// Port-level checker for the FIR filter, bound to the top level.
`timescale 1ns / 1ps
`include "fir_filter_fixed_coefficients_macros.svh"

module firfc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [firfc_pkg::DATA_W-1:0] rsp_filtered_out
);

   `FIRFC_ASSERT_RST(a_reset_empty, !rsp_valid, "rsp_valid high right after reset")
   `FIRFC_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_filtered_out), "stalled result beat changed")
   `FIRFC_ASSERT_NXT(a_result_due, req_valid && !req_stall, ##1 rsp_valid,
      "no result two cycles after an accepted beat")
   `FIRFC_ASSERT_IMP(a_idle_ready, !rsp_valid, !req_stall,
      "input stalled with empty output")

endmodule

bind fir_filter_fixed_coefficients firfc_checker u_firfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_filtered_out (rsp_filtered_out)
);
